/* sv/hect_pkg.sv */
// ----------------------------------------------------------------------------
// Hex edge contour tracer package
// Shared types, request codes and the fixed turn table of the tracer.
// ----------------------------------------------------------------------------
package hect_pkg;

  localparam int GRID_ROWS_DEF    = 32;
  localparam int GRID_COLS_DEF    = 32;
  localparam int MAX_SEGMENTS_DEF = 3072;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  localparam logic [1:0] SIDE_N  = 2'd0;
  localparam logic [1:0] SIDE_NE = 2'd1;
  localparam logic [1:0] SIDE_NW = 2'd2;

  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

  typedef struct packed {
    logic       req_type;
    logic [4:0] cell_row;
    logic [4:0] cell_col;
    logic [1:0] edge_side;
  } hect_in_t;

  typedef struct packed {
    logic [4:0] seg_row;
    logic [4:0] seg_col;
    logic [1:0] seg_side;
    logic       heading;
    logic       path_end;
    logic       all_done;
  } hect_out_t;

  typedef struct packed {
    logic [4:0] row;
    logic [4:0] col;
    logic [1:0] side;
  } seg_pos_t;

  typedef struct packed {
    logic [1:0] dr;
    logic [1:0] dc;
    logic [1:0] side;
    logic       head;
  } turn_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic add_rd;
    logic add_wr;
    logic scan_rd_order;
    logic scan_rd_map;
    logic scan_adv;
    logic scan_take;
    logic trace_clr;
    logic rd_left;
    logic step;
    logic end_path;
    logic emit_seg;
    logic emit_done;
  } hect_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic tracing;
    logic add_ok;
    logic scan_empty;
    logic scan_hit;
    logic cand_ok;
  } hect_sts_t;

  // Right candidate when left is low, left candidate otherwise.
  function automatic turn_t turn_lookup(input logic [1:0] side, input logic head,
                                        input logic left);
    turn_t t;
    case ({side, head, left})
      4'd0:    t = '{STEP_ZERO, STEP_ZERO, SIDE_NE, 1'b0};
      4'd1:    t = '{STEP_NEG,  STEP_POS,  SIDE_NW, 1'b0};
      4'd2:    t = '{STEP_ZERO, STEP_NEG,  SIDE_NE, 1'b1};
      4'd3:    t = '{STEP_ZERO, STEP_ZERO, SIDE_NW, 1'b1};
      4'd4:    t = '{STEP_ZERO, STEP_POS,  SIDE_NW, 1'b1};
      4'd5:    t = '{STEP_ZERO, STEP_POS,  SIDE_N,  1'b0};
      4'd6:    t = '{STEP_NEG,  STEP_POS,  SIDE_NW, 1'b0};
      4'd7:    t = '{STEP_ZERO, STEP_ZERO, SIDE_N,  1'b1};
      4'd8:    t = '{STEP_ZERO, STEP_ZERO, SIDE_N,  1'b0};
      4'd9:    t = '{STEP_ZERO, STEP_NEG,  SIDE_NE, 1'b1};
      4'd10:   t = '{STEP_POS,  STEP_NEG,  SIDE_N,  1'b1};
      4'd11:   t = '{STEP_POS,  STEP_NEG,  SIDE_NE, 1'b0};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

/* sv/hect_ctrl.sv */
// ----------------------------------------------------------------------------
// Hex edge contour tracer controller
// Sequences reset clearing, adds, start scans and trace steps of the datapath.
// ----------------------------------------------------------------------------
module hect_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_req_type,
  output logic                 busy,
  input  hect_pkg::hect_sts_t  sts,
  output hect_pkg::hect_cmd_t  cmd
);
  import hect_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ADD_CHK  = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_SCAN_ORD = 4'd4;
  localparam logic [3:0] S_SCAN_MAP = 4'd5;
  localparam logic [3:0] S_TRACE    = 4'd6;
  localparam logic [3:0] S_RIGHT    = 4'd7;
  localparam logic [3:0] S_LEFT     = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (in_req_type == REQ_ADD) begin
            cmd.add_rd = 1'b1;
            state_nxt  = S_ADD_CHK;
          end else if (sts.tracing) begin
            state_nxt = S_TRACE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_ADD_CHK: begin
        cmd.add_wr = sts.add_ok;
        state_nxt  = S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_empty) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.scan_rd_order = 1'b1;
          state_nxt         = S_SCAN_ORD;
        end
      end
      S_SCAN_ORD: begin
        cmd.scan_rd_map = 1'b1;
        state_nxt       = S_SCAN_MAP;
      end
      S_SCAN_MAP: begin
        if (sts.scan_hit) begin
          cmd.scan_take = 1'b1;
          state_nxt     = S_TRACE;
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_TRACE: begin
        cmd.trace_clr = 1'b1;
        state_nxt     = S_RIGHT;
      end
      S_RIGHT: begin
        if (sts.cand_ok) begin
          cmd.step     = 1'b1;
          cmd.emit_seg = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.rd_left = 1'b1;
          state_nxt   = S_LEFT;
        end
      end
      S_LEFT: begin
        cmd.emit_seg = 1'b1;
        cmd.step     = sts.cand_ok;
        cmd.end_path = !sts.cand_ok;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_seg || cmd.emit_done) |=> (state_r == S_IDLE))
    else $error("controller not idle after a result");

  a_right_after_trace: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RIGHT) |-> ($past(state_r) == S_TRACE))
    else $error("right candidate checked without a trace step");

endmodule

/* sv/hect_dp.sv */
// ----------------------------------------------------------------------------
// Hex edge contour tracer datapath
// Presence map with load slots, load order memory, scan and trace registers.
// ----------------------------------------------------------------------------
module hect_dp #(
  parameter int GRID_ROWS    = hect_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS    = hect_pkg::GRID_COLS_DEF,
  parameter int MAX_SEGMENTS = hect_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hect_pkg::hect_in_t   in_data,
  input  hect_pkg::hect_cmd_t  cmd,
  output hect_pkg::hect_sts_t  sts,
  output logic                 out_valid,
  output hect_pkg::hect_out_t  out_data
);
  import hect_pkg::*;

  localparam int EDGE_COUNT = GRID_ROWS * GRID_COLS * 3;
  localparam int EW         = $clog2(EDGE_COUNT);
  localparam int LW         = $clog2(MAX_SEGMENTS);
  localparam int SW         = $clog2(MAX_SEGMENTS + 1);

  typedef struct packed {
    logic [6:0] row;
    logic [6:0] col;
    logic [1:0] side;
    logic       head;
    logic       in_grid;
  } cand_t;

  function automatic logic [EW-1:0] edge_addr(input logic [6:0] row, input logic [6:0] col,
                                              input logic [1:0] side);
    return EW'((int'(row) * GRID_COLS + int'(col)) * 3 + int'(side));
  endfunction

  function automatic cand_t cand_calc(input seg_pos_t p, input logic head, input logic left);
    turn_t      t;
    logic [6:0] r;
    logic [6:0] c;
    cand_t      o;
    t = turn_lookup(p.side, head, left);
    r = {2'b00, p.row} + {{5{t.dr[1]}}, t.dr};
    c = {2'b00, p.col} + {{5{t.dc[1]}}, t.dc};
    o.row     = r;
    o.col     = c;
    o.side    = t.side;
    o.head    = t.head;
    o.in_grid = !r[6] && !c[6] && (int'(r) < GRID_ROWS) && (int'(c) < GRID_COLS);
    return o;
  endfunction

  logic [LW:0]    map_mem [EDGE_COUNT];
  seg_pos_t       ord_mem [MAX_SEGMENTS];

  logic [EW-1:0]  clr_cnt_r;
  logic [SW-1:0]  load_count_r;
  logic [SW-1:0]  start_scan_r;
  seg_pos_t       cur_r;
  logic           cur_head_r;
  logic           tracing_r;
  seg_pos_t       cap_r;
  logic           cap_ok_r;
  logic [LW:0]    map_rdata_r;
  seg_pos_t       ord_rdata_r;
  cand_t          cand_r;
  logic           out_valid_r;
  hect_out_t      out_r;

  logic           in_ok;
  cand_t          cand;
  logic           map_we;
  logic [EW-1:0]  map_waddr;
  logic [LW:0]    map_wdata;
  logic           map_re;
  logic [EW-1:0]  map_raddr;

  assign in_ok = (int'(in_data.cell_row) < GRID_ROWS) && (int'(in_data.cell_col) < GRID_COLS)
                 && (in_data.edge_side <= SIDE_NW);
  assign cand  = cand_calc(cur_r, cur_head_r, cmd.rd_left);

  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_cnt_r;
    map_wdata = '0;
    if (cmd.clr_step) begin
      map_we = 1'b1;
    end else if (cmd.add_wr) begin
      map_we    = 1'b1;
      map_waddr = edge_addr({2'b00, cap_r.row}, {2'b00, cap_r.col}, cap_r.side);
      map_wdata = {1'b1, load_count_r[LW-1:0]};
    end else if (cmd.trace_clr) begin
      map_we    = 1'b1;
      map_waddr = edge_addr({2'b00, cur_r.row}, {2'b00, cur_r.col}, cur_r.side);
    end
  end

  always_comb begin
    map_re    = 1'b0;
    map_raddr = edge_addr({2'b00, in_data.cell_row}, {2'b00, in_data.cell_col},
                          in_data.edge_side);
    if (cmd.add_rd) begin
      map_re = in_ok;
    end else if (cmd.scan_rd_map) begin
      map_re    = 1'b1;
      map_raddr = edge_addr({2'b00, ord_rdata_r.row}, {2'b00, ord_rdata_r.col},
                            ord_rdata_r.side);
    end else if (cmd.trace_clr || cmd.rd_left) begin
      map_re    = cand.in_grid;
      map_raddr = edge_addr(cand.row, cand.col, cand.side);
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rdata_r <= map_mem[map_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      ord_mem[load_count_r[LW-1:0]] <= cap_r;
    end
    if (cmd.scan_rd_order) begin
      ord_rdata_r <= ord_mem[start_scan_r[LW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_r    <= '{in_data.cell_row, in_data.cell_col, in_data.edge_side};
      cap_ok_r <= in_ok;
    end
    if (cmd.trace_clr || cmd.rd_left) begin
      cand_r <= cand;
    end
    if (cmd.emit_seg) begin
      out_r <= '{cur_r.row, cur_r.col, cur_r.side, cur_head_r, cmd.end_path, 1'b0};
    end else if (cmd.emit_done) begin
      out_r <= '{5'd0, 5'd0, SIDE_N, 1'b0, 1'b0, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      load_count_r <= '0;
      start_scan_r <= '0;
      cur_r        <= '0;
      cur_head_r   <= 1'b0;
      tracing_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_seg || cmd.emit_done;
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.add_wr) begin
        load_count_r <= load_count_r + 1'b1;
      end
      if (cmd.scan_adv) begin
        start_scan_r <= start_scan_r + 1'b1;
      end
      if (cmd.scan_take) begin
        cur_r      <= ord_rdata_r;
        cur_head_r <= 1'b0;
        tracing_r  <= 1'b1;
      end else if (cmd.step) begin
        cur_r      <= '{cand_r.row[4:0], cand_r.col[4:0], cand_r.side};
        cur_head_r <= cand_r.head;
      end
      if (cmd.end_path) begin
        tracing_r <= 1'b0;
      end
    end
  end

  assign sts.clr_last   = (clr_cnt_r == EW'(EDGE_COUNT - 1));
  assign sts.tracing    = tracing_r;
  assign sts.add_ok     = cap_ok_r && !map_rdata_r[LW] && (int'(load_count_r) < MAX_SEGMENTS);
  assign sts.scan_empty = (start_scan_r >= load_count_r);
  assign sts.scan_hit   = map_rdata_r[LW] && (map_rdata_r[LW-1:0] == start_scan_r[LW-1:0]);
  assign sts.cand_ok    = cand_r.in_grid && map_rdata_r[LW];

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_map_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (map_we && map_re) |-> (map_waddr != map_raddr))
    else $error("presence map read and write collide");

  a_load_cap: assert property (@(posedge clk) disable iff (!rst_n)
    int'(load_count_r) <= MAX_SEGMENTS)
    else $error("load count beyond capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    start_scan_r <= load_count_r)
    else $error("start scan passed the load count");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_done |-> !tracing_r)
    else $error("done beat while a path is active");

endmodule

/* sv/hex_edge_contour_tracer_top.sv */
// ----------------------------------------------------------------------------
// Hex edge contour tracer
// Collects hex-grid edge segments and returns them chained into contours.
//
//   Channel  Ports                   Handshake
//   input    start, busy, in_data    beat taken when start is high, busy low
//   result   out_valid, out_data     one-cycle strobe, no back-pressure
//
// An add reads the presence map, then writes it if accepted. A pull on an
// active path reads the right candidate, then the left one if needed. A pull
// that starts a path first scans load slots, reading the load order and then
// the presence map for each slot. After reset a clearing pass sweeps all
// GRID_ROWS*GRID_COLS*3 map entries, one entry per cycle, with busy high. The
// result side cannot stall; each pull yields exactly one beat, an add none.
// ----------------------------------------------------------------------------
module hex_edge_contour_tracer_top #(
  parameter int GRID_ROWS    = hect_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS    = hect_pkg::GRID_COLS_DEF,
  parameter int MAX_SEGMENTS = hect_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hect_pkg::hect_in_t   in_data,
  output logic                 out_valid,
  output hect_pkg::hect_out_t  out_data
);
  import hect_pkg::*;

  hect_cmd_t cmd;
  hect_sts_t sts;

  hect_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_data.req_type),
    .busy        (busy),
    .sts         (sts),
    .cmd         (cmd)
  );

  hect_dp #(
    .GRID_ROWS    (GRID_ROWS),
    .GRID_COLS    (GRID_COLS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/tb_hex_edge_contour_tracer_top.sv */
// ----------------------------------------------------------------------------
// Hex edge contour tracer testbench
// Drives add and pull requests into the tracer and compares every result
// beat, field by field, against a predictor of the grid, its load slots and
// the active path, or for typed directed rows their table entry. A short table
// of directed requests comes first; random blobs of edges, noise and drains
// follow. A final drain empties the store. The sender idles in random bursts.
// ----------------------------------------------------------------------------
module tb_hex_edge_contour_tracer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hect_pkg::*;

  localparam int EDGE_TOTAL = GRID_ROWS_DEF * GRID_COLS_DEF * 3;
  localparam int RAND_BEATS = 1850;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [1:0] SIDE_BAD = 2'd3;
  localparam hect_out_t SEG_DONE = '{5'd0, 5'd0, SIDE_N, 1'b0, 1'b0, 1'b1};
  localparam hect_out_t SEG_NONE = '0;

  typedef struct {
    int         dr;
    int         dc;
    logic [1:0] side;
    logic       head;
  } hop_t;

  typedef struct {
    hect_in_t  item;
    bit        typed;
    hect_out_t seg;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  hect_in_t  in_data = '0;
  logic      out_valid;
  hect_out_t out_data;

  hop_t hop_tab [12] = '{
    '{ 0,  0, SIDE_NE, 1'b0}, '{-1,  1, SIDE_NW, 1'b0},
    '{ 0, -1, SIDE_NE, 1'b1}, '{ 0,  0, SIDE_NW, 1'b1},
    '{ 0,  1, SIDE_NW, 1'b1}, '{ 0,  1, SIDE_N,  1'b0},
    '{-1,  1, SIDE_NW, 1'b0}, '{ 0,  0, SIDE_N,  1'b1},
    '{ 0,  0, SIDE_N,  1'b0}, '{ 0, -1, SIDE_NE, 1'b1},
    '{ 1, -1, SIDE_N,  1'b1}, '{ 1, -1, SIDE_NE, 1'b0}
  };

  plan_row_t directed_plan [23] = '{
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b1, SEG_DONE},
    '{'{REQ_ADD,  5'd5,  5'd5,  SIDE_BAD}, 1'b0, SEG_NONE},
    '{'{REQ_PULL, 5'd31, 5'd31, SIDE_BAD}, 1'b1, SEG_DONE},
    '{'{REQ_ADD,  5'd31, 5'd31, SIDE_NW},  1'b0, SEG_NONE},
    '{'{REQ_ADD,  5'd0,  5'd0,  SIDE_N},   1'b0, SEG_NONE},
    '{'{REQ_ADD,  5'd0,  5'd0,  SIDE_N},   1'b0, SEG_NONE},
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b1,
      '{5'd31, 5'd31, SIDE_NW, 1'b0, 1'b1, 1'b0}},
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b1,
      '{5'd0, 5'd0, SIDE_N, 1'b0, 1'b1, 1'b0}},
    '{'{REQ_PULL, 5'd17, 5'd9,  SIDE_NE},  1'b1, SEG_DONE},
    '{'{REQ_ADD,  5'd4,  5'd4,  SIDE_N},   1'b0, SEG_NONE},
    '{'{REQ_ADD,  5'd4,  5'd4,  SIDE_NE},  1'b0, SEG_NONE},
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b0, SEG_NONE},
    '{'{REQ_ADD,  5'd4,  5'd5,  SIDE_NW},  1'b0, SEG_NONE},
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b0, SEG_NONE},
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b0, SEG_NONE},
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b1, SEG_DONE},
    '{'{REQ_ADD,  5'd0,  5'd31, SIDE_NE},  1'b0, SEG_NONE},
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b1,
      '{5'd0, 5'd31, SIDE_NE, 1'b0, 1'b1, 1'b0}},
    '{'{REQ_ADD,  5'd31, 5'd0,  SIDE_N},   1'b0, SEG_NONE},
    '{'{REQ_ADD,  5'd30, 5'd1,  SIDE_NW},  1'b0, SEG_NONE},
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b0, SEG_NONE},
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b0, SEG_NONE},
    '{'{REQ_PULL, 5'd0,  5'd0,  SIDE_N},   1'b1, SEG_DONE}
  };

  bit        edge_live [EDGE_TOTAL];
  int        edge_slot [EDGE_TOTAL];
  int        slot_edge [MAX_SEGMENTS_DEF];
  int        slots_used = 0;
  int        scan_ptr = 0;
  int        walk_row = 0;
  int        walk_col = 0;
  int        walk_side = 0;
  bit        walk_head = 1'b0;
  bit        walking = 1'b0;
  int        sent_beats = 0;
  int        burst_left = 0;
  int        mismatch_count = 0;
  hect_out_t expected_segs [$];

  hex_edge_contour_tracer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int edge_id(input int r, input int c, input int s);
    return (r * GRID_COLS_DEF + c) * 3 + s;
  endfunction

  function automatic bit edge_on(input int r, input int c, input int s);
    if (r < 0 || r >= GRID_ROWS_DEF || c < 0 || c >= GRID_COLS_DEF) begin
      return 1'b0;
    end
    return edge_live[edge_id(r, c, s)];
  endfunction

  function automatic bit trace_step(input hect_in_t it, output hect_out_t seg);
    int   e;
    int   base;
    int   k;
    bit   hit;
    hop_t hop;
    seg = '0;
    e = 0;
    if (it.req_type == REQ_ADD) begin
      if (it.edge_side == SIDE_BAD) begin
        return 1'b0;
      end
      e = edge_id(it.cell_row, it.cell_col, it.edge_side);
      if (edge_live[e] || slots_used >= MAX_SEGMENTS_DEF) begin
        return 1'b0;
      end
      edge_live[e] = 1'b1;
      edge_slot[e] = slots_used;
      slot_edge[slots_used] = e;
      slots_used++;
      return 1'b0;
    end
    if (!walking) begin
      hit = 1'b0;
      while (!hit && scan_ptr < slots_used) begin
        e = slot_edge[scan_ptr];
        if (edge_live[e] && edge_slot[e] == scan_ptr) begin
          hit = 1'b1;
        end else begin
          scan_ptr++;
        end
      end
      if (!hit) begin
        seg.all_done = 1'b1;
        return 1'b1;
      end
      walk_side = e % 3;
      walk_col = (e / 3) % GRID_COLS_DEF;
      walk_row = (e / 3) / GRID_COLS_DEF;
      walk_head = 1'b0;
      walking = 1'b1;
    end
    seg.seg_row = 5'(walk_row);
    seg.seg_col = 5'(walk_col);
    seg.seg_side = 2'(walk_side);
    seg.heading = walk_head;
    edge_live[edge_id(walk_row, walk_col, walk_side)] = 1'b0;
    base = walk_side * 4 + int'(walk_head) * 2;
    hit = 1'b0;
    for (k = 0; k < 2 && !hit; k++) begin
      hop = hop_tab[base + k];
      if (edge_on(walk_row + hop.dr, walk_col + hop.dc, hop.side)) begin
        hit = 1'b1;
        walk_row = walk_row + hop.dr;
        walk_col = walk_col + hop.dc;
        walk_side = hop.side;
        walk_head = hop.head;
      end
    end
    seg.path_end = !hit;
    if (!hit) begin
      walking = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_beat(input hect_in_t it, input bit typed, input hect_out_t typed_seg,
                           output hect_out_t seg);
    hect_out_t pred;
    int        gap;
    in_data <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sent_beats++;
    if (trace_step(it, pred)) begin
      expected_segs.push_back(typed ? typed_seg : pred);
    end
    seg = pred;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_add(input int r, input int c, input int s);
    hect_in_t  it;
    hect_out_t seg;
    it = '{REQ_ADD, 5'(r), 5'(c), 2'(s)};
    send_beat(it, 1'b0, SEG_NONE, seg);
  endtask

  task automatic send_pull(output hect_out_t seg);
    hect_in_t it;
    it.req_type = REQ_PULL;
    it.cell_row = 5'($urandom_range(0, 31));
    it.cell_col = 5'($urandom_range(0, 31));
    it.edge_side = 2'($urandom_range(0, 3));
    send_beat(it, 1'b0, SEG_NONE, seg);
  endtask

  always @(posedge clk) begin
    hect_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_segs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: row %0d col %0d side %0d head %0d end %0d done %0d",
                   out_data.seg_row, out_data.seg_col, out_data.seg_side, out_data.heading,
                   out_data.path_end, out_data.all_done);
        end
      end else begin
        want = expected_segs.pop_front();
        if (out_data.seg_row !== want.seg_row || out_data.seg_col !== want.seg_col ||
            out_data.seg_side !== want.seg_side || out_data.heading !== want.heading ||
            out_data.path_end !== want.path_end || out_data.all_done !== want.all_done) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at %0t: exp row %0d col %0d side %0d head %0d end %0d done %0d",
                     $realtime, want.seg_row, want.seg_col, want.seg_side, want.heading,
                     want.path_end, want.all_done);
            $display("                 got row %0d col %0d side %0d head %0d end %0d done %0d",
                     out_data.seg_row, out_data.seg_col, out_data.seg_side, out_data.heading,
                     out_data.path_end, out_data.all_done);
          end
        end
      end
    end
  end

  initial begin
    hect_out_t seg;
    hect_out_t spare;
    hect_in_t  it;
    int        target;
    int        mode;
    int        r0;
    int        c0;
    int        hgt;
    int        wid;
    int        r;
    int        c;
    int        s;
    int        n;
    int        i;
    burst_left = $urandom_range(0, 12);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_plan[j]) begin
      send_beat(directed_plan[j].item, directed_plan[j].typed, directed_plan[j].seg, seg);
    end

    target = sent_beats + RAND_BEATS;
    while (sent_beats < target) begin
      mode = $urandom_range(0, 19);
      if (mode < 14) begin
        r0 = $urandom_range(0, GRID_ROWS_DEF - 1);
        c0 = $urandom_range(0, GRID_COLS_DEF - 1);
        hgt = $urandom_range(1, 4);
        wid = $urandom_range(1, 4);
        for (r = r0; r < r0 + hgt && r < GRID_ROWS_DEF; r++) begin
          for (c = c0; c < c0 + wid && c < GRID_COLS_DEF; c++) begin
            for (s = 0; s < 3; s++) begin
              if ($urandom_range(0, 9) < 8) begin
                send_add(r, c, s);
                if ($urandom_range(0, 9) == 0) begin
                  send_add(r, c, s);
                end
                if ($urandom_range(0, 9) == 0) begin
                  send_pull(seg);
                end
              end
            end
          end
        end
        n = $urandom_range(1, hgt * wid * 3 + 2);
        for (i = 0; i < n; i++) begin
          send_pull(seg);
        end
      end else if (mode < 18) begin
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) begin
          it.req_type = 1'($urandom_range(0, 1));
          it.cell_row = 5'($urandom_range(0, 31));
          it.cell_col = 5'($urandom_range(0, 31));
          it.edge_side = 2'($urandom_range(0, 3));
          send_beat(it, 1'b0, SEG_NONE, seg);
        end
      end else begin
        do send_pull(seg); while (!seg.all_done);
      end
    end

    do send_pull(seg); while (!seg.all_done);
    send_pull(spare);

    if (start) begin
      start <= 1'b0;
    end
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_hex_edge_contour_tracer_top: PASS");
    end else begin
      $display("tb_hex_edge_contour_tracer_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_hex_edge_contour_tracer_top: FAIL");
    $finish;
  end

endmodule
